### design/refcounted_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// Refcounted page allocator assertion macros
// Shared concurrent assertion helpers for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define RPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("refcounted page allocator assertion failed");

// next-cycle implication
`define RPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("refcounted page allocator assertion failed");

`endif

### design/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Types and constants shared by the refcounted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int ADDR_W    = 40;
    localparam int ACT_W     = 3;
    localparam int REF_W     = 8;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 8;
    localparam int PG_SHIFT  = 12;
    localparam int PG_SIZE   = 4096;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_INIT  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_TOP  = 8'd1;

    localparam logic [ADDR_W-1:0] POOL_BASE_RST = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] POOL_TOP_RST  = 40'h00_8800_0000;

    localparam logic [REF_W-1:0] REF_MAX = 8'hFF;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic walk_start;
        logic walk_step;
        logic mem_read;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic is_init;
        logic walk_done;
        logic out_free;
    } t_dp_sts;

endpackage

### design/rpa_if.sv
// ----------------------------------------------------------------------------
// rpa_if
// Request, response and configuration channels of the page allocator.
// ----------------------------------------------------------------------------
interface rpa_req_if import rpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] address;

    modport source(output valid, action, address, input ready);
    modport sink(input valid, action, address, output ready);
endinterface

interface rpa_rsp_if import rpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] page_address;
    logic [REF_W-1:0]  ref_count;
    logic              released;
    logic [STAT_W-1:0] status;

    modport source(output valid, page_address, ref_count, released, status, input ready);
    modport sink(input valid, page_address, ref_count, released, status, output ready);
endinterface

interface rpa_cfg_if import rpa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### design/rpa_ram.sv
// ----------------------------------------------------------------------------
// rpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer: accept, lookup, memory read, update, and the initialize walk.
// ----------------------------------------------------------------------------
module rpa_ctrl import rpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                if (i_sts.is_init) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_WALK;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_UPDATE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/rpa_dp.sv
// ----------------------------------------------------------------------------
// rpa_dp
// Datapath: pool registers, address check, free stack and count memories,
// and the response register.
// ----------------------------------------------------------------------------
`include "refcounted_page_allocator_macros.svh"

module rpa_dp import rpa_pkg::*; #(
    parameter int PAGES = 32768
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ADDR_W-1:0]    o_page_address,
    output logic [REF_W-1:0]     o_ref_count,
    output logic                 o_released,
    output logic [STAT_W-1:0]    o_status
);

    localparam int IW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW = $clog2(PAGES + 1);
    localparam int BW = ADDR_W + 1;
    localparam int WW = ADDR_W + 2;
    localparam int PW = BW - PG_SHIFT;
    localparam logic [BW-1:0] PG_LOW  = BW'(PG_SIZE - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(PAGES);

    logic [ADDR_W-1:0] r_pool_base;
    logic [ADDR_W-1:0] r_pool_top;
    logic [BW-1:0]     r_base_rnd;
    logic [ACT_W-1:0]  r_action;
    logic [ADDR_W-1:0] r_address;
    logic              r_pg_ok;
    logic [IW-1:0]     r_idx;
    logic [CW-1:0]     r_stack_cnt;
    logic [CW-1:0]     n_stack_cnt;
    logic [WW-1:0]     r_walk_addr;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_page_address;
    logic [REF_W-1:0]  r_ref_count;
    logic              r_released;
    logic [STAT_W-1:0] r_status;
    logic [ADDR_W-1:0] n_page_address;
    logic [REF_W-1:0]  n_ref_count;
    logic              n_released;
    logic [STAT_W-1:0] n_status;

    logic [BW-1:0] addr_ext;
    logic [BW-1:0] addr_diff;
    logic [PW-1:0] page_num;
    logic          pg_ok;
    logic          walk_go;
    logic [CW-1:0] cnt_m1;
    logic [BW-1:0] alloc_sum;
    logic [REF_W-1:0] ref_dec;

    logic             ref_we;
    logic [IW-1:0]    ref_waddr;
    logic [REF_W-1:0] ref_wdata;
    logic [REF_W-1:0] ref_rdata;
    logic             stk_we;
    logic [IW-1:0]    stk_waddr;
    logic [IW-1:0]    stk_wdata;
    logic [IW-1:0]    stk_rdata;

    // address check
    assign addr_ext  = {1'b0, r_address};
    assign addr_diff = addr_ext - r_base_rnd;
    assign page_num  = addr_diff[BW-1:PG_SHIFT];
    assign pg_ok     = (r_address[PG_SHIFT-1:0] == '0)
                    && (addr_ext >= r_base_rnd)
                    && ((addr_ext + BW'(PG_SIZE)) <= {1'b0, r_pool_top})
                    && (page_num < PW'(PAGES));

    assign walk_go   = (r_stack_cnt < CNT_MAX)
                    && ((r_walk_addr + WW'(PG_SIZE)) <= WW'(r_pool_top));
    assign cnt_m1    = r_stack_cnt - CW'(1);
    assign alloc_sum = r_base_rnd + (BW'(stk_rdata) << PG_SHIFT);
    assign ref_dec   = (ref_rdata != '0) ? ref_rdata - REF_W'(1) : ref_rdata;

    assign o_sts.is_init   = (r_action == ACT_INIT);
    assign o_sts.walk_done = !walk_go;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_stack_cnt    = r_stack_cnt;
        n_page_address = '0;
        n_ref_count    = '0;
        n_released     = 1'b0;
        n_status       = STAT_OK;
        ref_we         = 1'b0;
        ref_waddr      = r_idx;
        ref_wdata      = '0;
        stk_we         = 1'b0;
        stk_waddr      = r_stack_cnt[IW-1:0];
        stk_wdata      = r_idx;
        if (i_cmd.walk_start) begin
            n_stack_cnt = '0;
        end else if (i_cmd.walk_step && walk_go) begin
            ref_we      = 1'b1;
            ref_waddr   = r_stack_cnt[IW-1:0];
            ref_wdata   = '0;
            stk_we      = 1'b1;
            stk_wdata   = r_stack_cnt[IW-1:0];
            n_stack_cnt = r_stack_cnt + CW'(1);
        end else if (i_cmd.update) begin
            case (r_action)
                ACT_ALLOC: begin
                    if (r_stack_cnt == '0) begin
                        n_status = STAT_OOM;
                    end else begin
                        n_stack_cnt    = cnt_m1;
                        ref_we         = 1'b1;
                        ref_waddr      = stk_rdata;
                        ref_wdata      = REF_W'(1);
                        n_page_address = alloc_sum[ADDR_W-1:0];
                        n_ref_count    = REF_W'(1);
                    end
                end
                ACT_FREE: begin
                    if (!r_pg_ok) begin
                        n_status = STAT_BAD_ADDR;
                    end else begin
                        ref_we      = 1'b1;
                        ref_wdata   = ref_dec;
                        n_ref_count = ref_dec;
                        if (ref_dec == '0) begin
                            if (r_stack_cnt >= CNT_MAX) begin
                                n_status = STAT_OVERFLOW;
                            end else begin
                                stk_we      = 1'b1;
                                n_stack_cnt = r_stack_cnt + CW'(1);
                                n_released  = 1'b1;
                            end
                        end
                    end
                end
                ACT_ADD: begin
                    if (!r_pg_ok) begin
                        n_status = STAT_BAD_ADDR;
                    end else begin
                        ref_we      = 1'b1;
                        ref_wdata   = (ref_rdata == REF_MAX) ? ref_rdata
                                                             : ref_rdata + REF_W'(1);
                        n_ref_count = ref_wdata;
                    end
                end
                ACT_READ: begin
                    if (!r_pg_ok) begin
                        n_status = STAT_BAD_ADDR;
                    end else begin
                        n_ref_count = ref_rdata;
                    end
                end
                default: begin
                    n_status = STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= POOL_BASE_RST;
            r_pool_top  <= POOL_TOP_RST;
            r_stack_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == REG_POOL_BASE) begin
                r_pool_base <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == REG_POOL_TOP) begin
                r_pool_top <= i_cfg_data;
            end
            r_stack_cnt <= n_stack_cnt;
            if (i_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base_rnd <= ({1'b0, r_pool_base} + PG_LOW) & ~PG_LOW;
        if (i_cmd.capture) begin
            r_action  <= i_action;
            r_address <= i_address;
        end
        if (i_cmd.lookup) begin
            r_pg_ok <= pg_ok;
            r_idx   <= page_num[IW-1:0];
        end
        if (i_cmd.walk_start) begin
            r_walk_addr <= WW'(r_base_rnd);
        end else if (i_cmd.walk_step && walk_go) begin
            r_walk_addr <= r_walk_addr + WW'(PG_SIZE);
        end
        if (i_cmd.update) begin
            r_page_address <= n_page_address;
            r_ref_count    <= n_ref_count;
            r_released     <= n_released;
            r_status       <= n_status;
        end
    end

    rpa_ram #(
        .WIDTH(REF_W),
        .DEPTH(PAGES)
    ) u_ref_ram (
        .i_clk  (i_clk),
        .i_we   (ref_we),
        .i_waddr(ref_waddr),
        .i_wdata(ref_wdata),
        .i_re   (i_cmd.mem_read),
        .i_raddr(r_idx),
        .o_rdata(ref_rdata)
    );

    rpa_ram #(
        .WIDTH(IW),
        .DEPTH(PAGES)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_re   (i_cmd.mem_read),
        .i_raddr(cnt_m1[IW-1:0]),
        .o_rdata(stk_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_page_address;
    assign o_ref_count    = r_ref_count;
    assign o_released     = r_released;
    assign o_status       = r_status;

    `RPA_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_stack_cnt <= CNT_MAX)
    `RPA_ASSERT_IMP(a_push_room, i_clk, i_rst_n, stk_we, r_stack_cnt < CNT_MAX)
    `RPA_ASSERT_NXT(a_alloc_pop, i_clk, i_rst_n,
        i_cmd.update && r_action == ACT_ALLOC && r_stack_cnt != '0,
        r_stack_cnt + CW'(1) == $past(r_stack_cnt))

endmodule

### design/refcounted_page_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Free-list page allocator with 8-bit reference counts per page.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one action (allocate, free, add reference, read reference,
//   initialize) and a page address; every request transaction yields exactly
//   one o_rsp transaction with page_address, ref_count, released and status.
//   i_cfg writes pool_base (index 0) and pool_top (index 1); it is ready
//   whenever reset is released. The user must see that it is written only
//   while the block is idle; the block itself does not enforce this.
//   A request is accepted, checked, its RAMs read and written back, and
//   the response registered, through the idle, lookup, read and update
//   states; a new request is accepted only after the last one's update.
//   Initialize walks the pool one page per cycle through both RAMs.
//   Reset empties the free stack and restores the pool registers; RAM
//   contents are undefined until initialize writes them.
//   The response sits in an output register; a stalled receiver holds it,
//   and the next request may be accepted and processed up to its update
//   step, where it waits until the register frees.
// ----------------------------------------------------------------------------
module refcounted_page_allocator import rpa_pkg::*; #(
    parameter int PAGES = 32768
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpa_req_if.sink    i_req,
    rpa_rsp_if.source  o_rsp,
    rpa_cfg_if.sink    i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = i_rst_n;

    rpa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(i_req.ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    rpa_dp #(
        .PAGES(PAGES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_req.action),
        .i_address     (i_req.address),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_page_address(o_rsp.page_address),
        .o_ref_count   (o_rsp.ref_count),
        .o_released    (o_rsp.released),
        .o_status      (o_rsp.status)
    );

endmodule
